[rtl/core/lgac_pkg.sv]
package lgac_pkg;

    localparam int STATE_COUNT    = 6;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int DATA_W         = 16;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int PAIR_W         = PROD_W + 1;
    localparam int SUM_W          = PROD_W + 3;
    localparam int ADDR_W         = 6;
    localparam int CFG_W          = 64;
    localparam int LIMIT_W        = 15;

    localparam logic [LIMIT_W-1:0] MAX_ANGLE_RESET = 15'd4096;

    typedef enum logic [2:0] {
        REG_PITCH_GAINS_A  = 3'd0,
        REG_YAW_GAINS_A    = 3'd1,
        REG_RATE_GAINS_B   = 3'd2,
        REG_MAX_ANGLE      = 3'd3,
        REG_CONTROL_ENABLE = 3'd4
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_vec [STATE_COUNT];

    typedef struct packed {
        logic [CFG_W-1:0]   pitch_gains_a;
        logic [CFG_W-1:0]   yaw_gains_a;
        logic [CFG_W-1:0]   rate_gains_b;
        logic [LIMIT_W-1:0] max_angle;
        logic               control_enable;
    } t_cfg;

endpackage

[rtl/core/lqr_gimbal_angle_controller_core.sv]
// LQR state-feedback gimbal controller. Each request on s_tdata carries one attitude
// sample (quaternion x, y, z and body rates x, y, z, signed Q2.14); the block returns
// pitch and yaw gimbal angles in Q2.14 radians, each the negated dot product of the
// sample with a Q8.8 gain row, rounded and clamped to +/- max_angle, with saturation
// flags. Both angles read zero while control_enable is low. A sample is accepted every
// cycle unless the pipeline is held; its result passes the multiply, pair add, total
// add and round-and-clamp registers in turn; the whole pipeline holds while m_tready
// is low with a result waiting. Registers sit at byte addresses 0x00, 0x08, 0x10,
// 0x18, 0x20 and should be written only while no sample is in flight.
module lqr_gimbal_angle_controller_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // quat_x, quat_y, quat_z, rate_x, rate_y, rate_z
    input  logic [95:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // pitch_angle, yaw_angle, pitch_saturated, yaw_saturated, zero pad
    output logic [39:0]                  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgac_pkg::ADDR_W-1:0]  paddr,
    input  logic [lgac_pkg::CFG_W-1:0]   pwdata,
    output logic [lgac_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);

    localparam int DW = lgac_pkg::DATA_W;

    lgac_pkg::t_cfg  w_cfg;
    lgac_pkg::t_vec  w_state;
    lgac_pkg::t_vec  w_gp;
    lgac_pkg::t_vec  w_gy;
    logic            w_en;
    logic [3:0]      r_valid;
    logic [3:0]      n_valid;
    logic signed [lgac_pkg::SUM_W-1:0] w_psum;
    logic signed [lgac_pkg::SUM_W-1:0] w_ysum;
    logic signed [DW-1:0] w_pitch;
    logic signed [DW-1:0] w_yaw;
    logic            w_psat;
    logic            w_ysat;

    lgac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        for (int i = 0; i < lgac_pkg::STATE_COUNT; i++) begin
            w_state[i] = $signed(s_tdata[DW*i +: DW]);
        end
        for (int i = 0; i < 4; i++) begin
            w_gp[i] = $signed(w_cfg.pitch_gains_a[DW*i +: DW]);
            w_gy[i] = $signed(w_cfg.yaw_gains_a[DW*i +: DW]);
        end
        w_gp[4] = $signed(w_cfg.rate_gains_b[15:0]);
        w_gp[5] = $signed(w_cfg.rate_gains_b[31:16]);
        w_gy[4] = $signed(w_cfg.rate_gains_b[47:32]);
        w_gy[5] = $signed(w_cfg.rate_gains_b[63:48]);
    end

    // whole pipeline advances unless a finished result is held
    assign w_en     = !r_valid[3] || m_tready;
    assign s_tready = w_en;
    assign n_valid  = {r_valid[2:0], s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= n_valid;
        end
    end

    lgac_mac u_mac_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_state (w_state),
        .i_gain  (w_gp),
        .o_sum   (w_psum)
    );

    lgac_mac u_mac_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_state (w_state),
        .i_gain  (w_gy),
        .o_sum   (w_ysum)
    );

    lgac_clamp u_clamp_pitch (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sum    (w_psum),
        .i_limit  (w_cfg.max_angle),
        .i_enable (w_cfg.control_enable),
        .o_angle  (w_pitch),
        .o_sat    (w_psat)
    );

    lgac_clamp u_clamp_yaw (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sum    (w_ysum),
        .i_limit  (w_cfg.max_angle),
        .i_enable (w_cfg.control_enable),
        .o_angle  (w_yaw),
        .o_sat    (w_ysat)
    );

    assign m_tvalid = r_valid[3];
    assign m_tdata  = {6'b0, w_ysat, w_psat, w_yaw, w_pitch};

endmodule

[rtl/core/lgac_regs.sv]
module lgac_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lgac_pkg::ADDR_W-1:0]      paddr,
    input  logic [lgac_pkg::CFG_W-1:0]       pwdata,
    output logic [lgac_pkg::CFG_W-1:0]       prdata,
    output logic                             pready,
    output lgac_pkg::t_cfg                   o_cfg
);

    lgac_pkg::t_cfg   r_cfg;
    lgac_pkg::t_cfg   n_cfg;
    lgac_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = lgac_pkg::t_reg_idx'(paddr[lgac_pkg::ADDR_W-1:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                lgac_pkg::REG_PITCH_GAINS_A:  n_cfg.pitch_gains_a  = pwdata;
                lgac_pkg::REG_YAW_GAINS_A:    n_cfg.yaw_gains_a    = pwdata;
                lgac_pkg::REG_RATE_GAINS_B:   n_cfg.rate_gains_b   = pwdata;
                lgac_pkg::REG_MAX_ANGLE:
                    n_cfg.max_angle = pwdata[lgac_pkg::LIMIT_W-1:0];
                lgac_pkg::REG_CONTROL_ENABLE: n_cfg.control_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lgac_pkg::REG_PITCH_GAINS_A:  prdata = r_cfg.pitch_gains_a;
            lgac_pkg::REG_YAW_GAINS_A:    prdata = r_cfg.yaw_gains_a;
            lgac_pkg::REG_RATE_GAINS_B:   prdata = r_cfg.rate_gains_b;
            lgac_pkg::REG_MAX_ANGLE:
                prdata = {{(lgac_pkg::CFG_W-lgac_pkg::LIMIT_W){1'b0}}, r_cfg.max_angle};
            lgac_pkg::REG_CONTROL_ENABLE:
                prdata = {{(lgac_pkg::CFG_W-1){1'b0}}, r_cfg.control_enable};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_gains_a  <= '0;
            r_cfg.yaw_gains_a    <= '0;
            r_cfg.rate_gains_b   <= '0;
            r_cfg.max_angle      <= lgac_pkg::MAX_ANGLE_RESET;
            r_cfg.control_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/lgac_mac.sv]
module lgac_mac (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  lgac_pkg::t_vec                      i_state,
    input  lgac_pkg::t_vec                      i_gain,
    output logic signed [lgac_pkg::SUM_W-1:0]   o_sum
);

    localparam int PAIRS = lgac_pkg::STATE_COUNT / 2;

    logic signed [lgac_pkg::PROD_W-1:0] r_prod [lgac_pkg::STATE_COUNT];
    logic signed [lgac_pkg::PROD_W-1:0] n_prod [lgac_pkg::STATE_COUNT];
    logic signed [lgac_pkg::PAIR_W-1:0] r_pair [PAIRS];
    logic signed [lgac_pkg::PAIR_W-1:0] n_pair [PAIRS];
    logic signed [lgac_pkg::SUM_W-1:0]  r_sum;
    logic signed [lgac_pkg::SUM_W-1:0]  n_sum;

    always_comb begin
        for (int i = 0; i < lgac_pkg::STATE_COUNT; i++) begin
            n_prod[i] = i_state[i] * i_gain[i];
        end
        for (int j = 0; j < PAIRS; j++) begin
            n_pair[j] = lgac_pkg::PAIR_W'(r_prod[2*j]) + lgac_pkg::PAIR_W'(r_prod[2*j+1]);
        end
        n_sum = '0;
        for (int j = 0; j < PAIRS; j++) begin
            n_sum = n_sum + lgac_pkg::SUM_W'(r_pair[j]);
        end
    end

    // products, pair sums, total: one register stage each
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_pair <= n_pair;
            r_sum  <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[rtl/core/lgac_clamp.sv]
module lgac_clamp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lgac_pkg::SUM_W-1:0]   i_sum,
    input  logic [lgac_pkg::LIMIT_W-1:0]        i_limit,
    input  logic                                i_enable,
    output logic signed [lgac_pkg::DATA_W-1:0]  o_angle,
    output logic                                o_sat
);

    localparam int BIAS_W = lgac_pkg::SUM_W + 2;
    localparam int HALF   = (lgac_pkg::GAIN_FRAC_BITS == 0) ? 0 :
                            (1 << (lgac_pkg::GAIN_FRAC_BITS - 1));

    logic signed [BIAS_W-1:0]           w_biased;
    logic signed [BIAS_W-1:0]           w_val;
    logic signed [BIAS_W-1:0]           w_lim;
    logic signed [lgac_pkg::DATA_W-1:0] n_angle;
    logic                               n_sat;
    logic signed [lgac_pkg::DATA_W-1:0] r_angle;
    logic                               r_sat;

    always_comb begin
        // negate and round to nearest, ties up
        w_biased = BIAS_W'(HALF) - BIAS_W'(i_sum);
        w_val    = w_biased >>> lgac_pkg::GAIN_FRAC_BITS;
        w_lim    = BIAS_W'($signed({1'b0, i_limit}));
        n_sat    = 1'b0;
        if (w_val > w_lim) begin
            n_angle = lgac_pkg::DATA_W'(w_lim);
            n_sat   = 1'b1;
        end else if (w_val < -w_lim) begin
            n_angle = lgac_pkg::DATA_W'(-w_lim);
            n_sat   = 1'b1;
        end else begin
            n_angle = lgac_pkg::DATA_W'(w_val);
        end
        if (!i_enable) begin
            n_angle = '0;
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
            r_sat   <= n_sat;
        end
    end

    assign o_angle = r_angle;
    assign o_sat   = r_sat;

endmodule
